FILE: rtl/ecnfa_pkg.sv
// shared widths, command codes and register indexes of the ecn fraction alpha estimator
package ecnfa_pkg;

   localparam int SEQ_W  = 32;
   localparam int MSS_W  = 16;
   localparam int CMD_W  = 2;
   localparam int ALPHA_OUT_W = 11;
   localparam int GAIN_W = 4;

   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 11;

   // item commands
   localparam logic [CMD_W-1:0] CMD_ACK  = 2'd0;
   localparam logic [CMD_W-1:0] CMD_LOSS = 2'd1;
   localparam logic [CMD_W-1:0] CMD_INIT = 2'd2;

   // register indexes
   localparam logic [CSR_INDEX_W-1:0] CSR_GAIN_SHIFT    = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_CLAMP_ON_LOSS = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_INITIAL_ALPHA = 2'd2;

   // largest usable gain shift
   localparam logic [GAIN_W-1:0] GAIN_MAX = 4'd10;

   // fraction scale shift and threshold shift
   localparam int FRAC_SHIFT = 10;
   localparam int THR_SHIFT  = 11;

   // threshold floor
   localparam logic [63:0] THR_FLOOR = 64'd2;

   typedef logic [SEQ_W-1:0] seq_type;

endpackage

FILE: rtl/ecnfa_req_if.sv
// input item channel of the ecn fraction alpha estimator
interface ecnfa_req_if;
   import ecnfa_pkg::*;

   logic                  valid;
   logic                  ready;
   logic [CMD_W-1:0]      cmd;
   seq_type               ack_point;
   seq_type               send_next;
   logic                  ece_flag;
   logic                  window_update_flag;
   logic [MSS_W-1:0]      segment_size;
   seq_type               cwnd;

   modport source (output valid, cmd, ack_point, send_next, ece_flag, window_update_flag,
                   segment_size, cwnd, input ready);
   modport sink   (input valid, cmd, ack_point, send_next, ece_flag, window_update_flag,
                   segment_size, cwnd, output ready);
endinterface

FILE: rtl/ecnfa_rsp_if.sv
// result channel of the ecn fraction alpha estimator
interface ecnfa_rsp_if;
   import ecnfa_pkg::*;

   logic                    valid;
   logic                    ready;
   logic [ALPHA_OUT_W-1:0]  alpha;
   seq_type                 slow_start_threshold;
   logic                    round_closed;
   seq_type                 marked_bytes;
   seq_type                 total_bytes;

   modport source (output valid, alpha, slow_start_threshold, round_closed, marked_bytes,
                   total_bytes, input ready);
   modport sink   (input valid, alpha, slow_start_threshold, round_closed, marked_bytes,
                   total_bytes, output ready);
endinterface

FILE: rtl/ecnfa_csr_if.sv
// register write channel of the ecn fraction alpha estimator
interface ecnfa_csr_if;
   import ecnfa_pkg::*;

   logic                    valid;
   logic                    ready;
   logic [CSR_INDEX_W-1:0]  index;
   logic [CSR_DATA_W-1:0]   data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

FILE: rtl/ecn_fraction_alpha_estimator.sv
// top level of the ecn fraction alpha estimator with its divider and sequencer
// steps: a loss, init or unused command runs EXEC, MUL, FIN; an ack that leaves the round
//   open runs EXEC, ADD, MUL, FIN; an ack that closes a round runs PREP, DIV, ALPHA after ADD
// a new item is taken only in IDLE, once the previous result is in the output register;
//   the 32-step restoring divider forming the marked fraction gives one quotient bit per cycle
// the block takes a new item while the previous result still waits in the output register
// reset (synchronous, active high): registers to defaults, alpha to ALPHA_MAX, counters
//   and marks to zero, result channel empty
module ecn_fraction_alpha_estimator #(
   parameter int ALPHA_MAX = 1024
) (
   input  logic                clock,
   input  logic                reset,
   ecnfa_req_if.sink           req,
   ecnfa_rsp_if.source         rsp,
   ecnfa_csr_if.sink           csr
);
   import ecnfa_pkg::*;

   localparam int AW = $clog2(ALPHA_MAX + 1);
   localparam int PW = SEQ_W + AW;
   localparam logic [AW-1:0]    AMAX_A  = AW'(ALPHA_MAX);
   localparam logic [SEQ_W-1:0] AMAX_32 = SEQ_W'(ALPHA_MAX);
   localparam int CNT_W = $clog2(SEQ_W);
   localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(SEQ_W - 1);

   // sequencer states
   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_EXEC  = 3'd1;
   localparam logic [2:0] S_ADD   = 3'd2;
   localparam logic [2:0] S_PREP  = 3'd3;
   localparam logic [2:0] S_DIV   = 3'd4;
   localparam logic [2:0] S_ALPHA = 3'd5;
   localparam logic [2:0] S_MUL   = 3'd6;
   localparam logic [2:0] S_FIN   = 3'd7;

   logic [2:0]              state_ff, state_in;
   logic [GAIN_W-1:0]       gain_ff, gain_in;
   logic                    clamp_ff, clamp_in;
   logic [CSR_DATA_W-1:0]   init_alpha_ff, init_alpha_in;
   logic [AW-1:0]           alpha_ff, alpha_in;
   seq_type                 marked_ff, marked_in;
   seq_type                 total_ff, total_in;
   seq_type                 last_ack_ff, last_ack_in;
   seq_type                 round_end_ff, round_end_in;
   logic                    rsp_valid_ff, rsp_valid_in;

   // captured item
   logic [CMD_W-1:0]        cmd_ff, cmd_in;
   seq_type                 ack_ff, ack_in;
   seq_type                 nxt_ff, nxt_in;
   logic                    ece_ff, ece_in;
   logic                    wu_ff, wu_in;
   logic [MSS_W-1:0]        mss_ff, mss_in;
   seq_type                 cwnd_ff, cwnd_in;

   // working registers
   seq_type                 bytes_ff, bytes_in;
   logic                    closed_ff, closed_in;
   logic [AW-1:0]           keep_ff, keep_in;
   seq_type                 rem_ff, rem_in;
   seq_type                 quo_ff, quo_in;
   seq_type                 dvs_ff, dvs_in;
   logic [CNT_W-1:0]        cnt_ff, cnt_in;
   logic [PW-1:0]           prod_ff, prod_in;

   // result register
   logic [ALPHA_OUT_W-1:0]  out_alpha_ff, out_alpha_in;
   seq_type                 out_thr_ff, out_thr_in;
   logic                    out_closed_ff, out_closed_in;
   seq_type                 out_marked_ff, out_marked_in;
   seq_type                 out_total_ff, out_total_in;

   logic [GAIN_W-1:0]       gain_sat;
   seq_type                 ack_diff;
   seq_type                 mark_diff;
   seq_type                 numerator;
   logic [SEQ_W:0]          div_shifted;
   logic [SEQ_W+1:0]        div_trial;
   logic                    div_ge;
   seq_type                 alpha_sum;
   logic [63:0]             thr_diff;
   seq_type                 thr_value;
   logic [AW+ALPHA_OUT_W-1:0] alpha_ext;
   logic                    out_free;

   // saturated gain and the shared datapath pieces
   assign gain_sat    = (gain_ff > GAIN_MAX) ? GAIN_MAX : gain_ff;
   assign ack_diff    = ack_ff - last_ack_ff;
   assign mark_diff   = ack_ff - round_end_ff;
   assign numerator   = marked_ff << (GAIN_MAX - gain_sat);
   assign div_shifted = {rem_ff, quo_ff[SEQ_W-1]};
   assign div_trial   = {1'b0, div_shifted} - {2'b00, dvs_ff};
   assign div_ge      = !div_trial[SEQ_W+1];
   assign alpha_sum   = SEQ_W'(keep_ff) + quo_ff;
   assign thr_diff    = {32'd0, cwnd_ff} - 64'(prod_ff >> THR_SHIFT);
   assign thr_value   = (thr_diff < THR_FLOOR) ? SEQ_W'(THR_FLOOR) : thr_diff[SEQ_W-1:0];
   assign alpha_ext   = {{ALPHA_OUT_W{1'b0}}, alpha_ff};
   assign out_free    = !rsp_valid_ff || rsp.ready;

   assign req.ready = (state_ff == S_IDLE);
   assign csr.ready = 1'b1;

   assign rsp.valid                = rsp_valid_ff;
   assign rsp.alpha                = out_alpha_ff;
   assign rsp.slow_start_threshold = out_thr_ff;
   assign rsp.round_closed         = out_closed_ff;
   assign rsp.marked_bytes         = out_marked_ff;
   assign rsp.total_bytes          = out_total_ff;

   // sequencer and next values
   always_comb begin
      state_in      = state_ff;
      gain_in       = gain_ff;
      clamp_in      = clamp_ff;
      init_alpha_in = init_alpha_ff;
      alpha_in      = alpha_ff;
      marked_in     = marked_ff;
      total_in      = total_ff;
      last_ack_in   = last_ack_ff;
      round_end_in  = round_end_ff;
      rsp_valid_in  = rsp_valid_ff;
      cmd_in        = cmd_ff;
      ack_in        = ack_ff;
      nxt_in        = nxt_ff;
      ece_in        = ece_ff;
      wu_in         = wu_ff;
      mss_in        = mss_ff;
      cwnd_in       = cwnd_ff;
      bytes_in      = bytes_ff;
      closed_in     = closed_ff;
      keep_in       = keep_ff;
      rem_in        = rem_ff;
      quo_in        = quo_ff;
      dvs_in        = dvs_ff;
      cnt_in        = cnt_ff;
      prod_in       = prod_ff;
      out_alpha_in  = out_alpha_ff;
      out_thr_in    = out_thr_ff;
      out_closed_in = out_closed_ff;
      out_marked_in = out_marked_ff;
      out_total_in  = out_total_ff;

      // register writes
      if (csr.valid) begin
         unique case (csr.index)
            CSR_GAIN_SHIFT:    gain_in       = csr.data[GAIN_W-1:0];
            CSR_CLAMP_ON_LOSS: clamp_in      = csr.data[0];
            CSR_INITIAL_ALPHA: init_alpha_in = csr.data;
            default: ;
         endcase
      end

      // result taken downstream
      if (rsp_valid_ff && rsp.ready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         S_IDLE: begin
            if (req.valid) begin
               cmd_in    = req.cmd;
               ack_in    = req.ack_point;
               nxt_in    = req.send_next;
               ece_in    = req.ece_flag;
               wu_in     = req.window_update_flag;
               mss_in    = req.segment_size;
               cwnd_in   = req.cwnd;
               closed_in = 1'b0;
               state_in  = S_EXEC;
            end
         end
         S_EXEC: begin
            state_in = S_MUL;
            case (cmd_ff)
               CMD_ACK: begin
                  bytes_in = (ack_diff == '0 && !wu_ff) ? SEQ_W'(mss_ff) : ack_diff;
                  state_in = S_ADD;
               end
               CMD_LOSS: begin
                  if (clamp_ff) begin
                     alpha_in = AMAX_A;
                  end
               end
               CMD_INIT: begin
                  last_ack_in  = ack_ff;
                  alpha_in     = (SEQ_W'(init_alpha_ff) > AMAX_32) ? AMAX_A
                                                                    : AW'(init_alpha_ff);
                  round_end_in = nxt_ff;
                  marked_in    = '0;
                  total_in     = '0;
               end
               default: ;
            endcase
         end
         // count the acked bytes and check the round end mark
         S_ADD: begin
            if (bytes_ff != '0) begin
               total_in    = total_ff + bytes_ff;
               last_ack_in = ack_ff;
               if (ece_ff) begin
                  marked_in = marked_ff + bytes_ff;
               end
            end
            closed_in = !mark_diff[SEQ_W-1];
            keep_in   = alpha_ff - (alpha_ff >> gain_sat);
            state_in  = mark_diff[SEQ_W-1] ? S_MUL : S_PREP;
         end
         // load the divider with the scaled marked count over the total
         S_PREP: begin
            rem_in   = '0;
            quo_in   = numerator;
            dvs_in   = (total_ff == '0) ? SEQ_W'(1) : total_ff;
            cnt_in   = CNT_LAST;
            state_in = S_DIV;
         end
         // one quotient bit per cycle
         S_DIV: begin
            rem_in = div_ge ? div_trial[SEQ_W-1:0] : div_shifted[SEQ_W-1:0];
            quo_in = {quo_ff[SEQ_W-2:0], div_ge};
            cnt_in = cnt_ff - CNT_W'(1);
            if (cnt_ff == '0) begin
               state_in = S_ALPHA;
            end
         end
         // ewma step, clamp, new round
         S_ALPHA: begin
            alpha_in     = (alpha_sum > AMAX_32) ? AMAX_A : AW'(alpha_sum);
            round_end_in = nxt_ff;
            marked_in    = '0;
            total_in     = '0;
            state_in     = S_MUL;
         end
         S_MUL: begin
            prod_in  = PW'(cwnd_ff) * PW'(alpha_ff);
            state_in = S_FIN;
         end
         // hand the result to the output register once it is free
         S_FIN: begin
            if (out_free) begin
               out_alpha_in  = alpha_ext[ALPHA_OUT_W-1:0];
               out_thr_in    = thr_value;
               out_closed_in = closed_ff;
               out_marked_in = marked_ff;
               out_total_in  = total_ff;
               rsp_valid_in  = 1'b1;
               state_in      = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   // control and estimator state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         gain_ff       <= 4'd4;
         clamp_ff      <= 1'b0;
         init_alpha_ff <= 11'd1024;
         alpha_ff      <= AMAX_A;
         marked_ff     <= '0;
         total_ff      <= '0;
         last_ack_ff   <= '0;
         round_end_ff  <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         gain_ff       <= gain_in;
         clamp_ff      <= clamp_in;
         init_alpha_ff <= init_alpha_in;
         alpha_ff      <= alpha_in;
         marked_ff     <= marked_in;
         total_ff      <= total_in;
         last_ack_ff   <= last_ack_in;
         round_end_ff  <= round_end_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // payload and working registers
   always_ff @(posedge clock) begin
      cmd_ff        <= cmd_in;
      ack_ff        <= ack_in;
      nxt_ff        <= nxt_in;
      ece_ff        <= ece_in;
      wu_ff         <= wu_in;
      mss_ff        <= mss_in;
      cwnd_ff       <= cwnd_in;
      bytes_ff      <= bytes_in;
      closed_ff     <= closed_in;
      keep_ff       <= keep_in;
      rem_ff        <= rem_in;
      quo_ff        <= quo_in;
      dvs_ff        <= dvs_in;
      cnt_ff        <= cnt_in;
      prod_ff       <= prod_in;
      out_alpha_ff  <= out_alpha_in;
      out_thr_ff    <= out_thr_in;
      out_closed_ff <= out_closed_in;
      out_marked_ff <= out_marked_in;
      out_total_ff  <= out_total_in;
   end

endmodule
